// ===== sv/facp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// facp_pkg
// Types, byte codes and sizes shared by the framed ASCII command parser.
// ----------------------------------------------------------------------------
package facp_pkg;

	localparam int TEXT_BYTES = 20;
	localparam int TEXT_LEN_W = $clog2(TEXT_BYTES);

	localparam logic [7:0] BYTE_NUL   = 8'h00;
	localparam logic [7:0] BYTE_STX   = 8'h02;
	localparam logic [7:0] BYTE_ETX   = 8'h03;
	localparam logic [7:0] BYTE_SPACE = 8'h20;
	localparam logic [7:0] BYTE_TAB   = 8'h09;
	localparam logic [7:0] BYTE_CR    = 8'h0D;
	localparam logic [7:0] BYTE_PLUS  = 8'h2B;
	localparam logic [7:0] BYTE_MINUS = 8'h2D;
	localparam logic [7:0] BYTE_ZERO  = 8'h30;
	localparam logic [7:0] BYTE_NINE  = 8'h39;
	localparam logic [7:0] LETTER_M   = 8'h4D;
	localparam logic [7:0] LETTER_V   = 8'h56;
	localparam logic [7:0] LETTER_D   = 8'h44;
	localparam logic [7:0] LETTER_E   = 8'h45;
	localparam logic [7:0] LETTER_R   = 8'h52;

	localparam logic [31:0] MAG_CAP = 32'h8000_0000;
	localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

	typedef logic [7:0]  rx_byte_t;
	typedef logic [2:0]  command_t;
	typedef logic signed [31:0] value_t;

	typedef enum logic [2:0] {
		KIND_NONE = 3'd0,
		KIND_M    = 3'd1,
		KIND_V    = 3'd2,
		KIND_D    = 3'd3,
		KIND_E    = 3'd4,
		KIND_R    = 3'd5
	} cmd_kind_t;

	typedef enum logic [2:0] {
		PH_SKIP = 3'b001,
		PH_NUM  = 3'b010,
		PH_STOP = 3'b100
	} num_phase_t;

	function automatic cmd_kind_t letter_kind(input logic [7:0] b);
		cmd_kind_t k;
		begin
			unique case (b)
				LETTER_M: k = KIND_M;
				LETTER_V: k = KIND_V;
				LETTER_D: k = KIND_D;
				LETTER_E: k = KIND_E;
				LETTER_R: k = KIND_R;
				default:  k = KIND_NONE;
			endcase
			return k;
		end
	endfunction

endpackage
`default_nettype wire

// ===== sv/facp_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// facp_in_if
// Received byte channel: valid/ready handshake with one byte per beat.
// ----------------------------------------------------------------------------
interface facp_in_if;
	import facp_pkg::*;

	logic     valid;
	logic     ready;
	rx_byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== sv/facp_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// facp_out_if
// Decoded command channel: valid/ready handshake, command and value per beat.
// ----------------------------------------------------------------------------
interface facp_out_if;
	import facp_pkg::*;

	logic     valid;
	logic     ready;
	command_t command;
	value_t   value;

	modport source (output valid, output command, output value, input ready);
	modport sink   (input valid, input command, input value, output ready);
endinterface
`default_nettype wire

// ===== sv/framed_ascii_command_parser_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// framed_ascii_command_parser_top
// Parses STX / letter / decimal text / ETX frames into command beats.
//
// Channels: rx carries one received byte per beat; res carries one
// command (0 M, 1 V, 2 D, 3 E, 4 R) and its saturated signed value per
// closed frame that had a command letter.
// Throughput: one byte per cycle unless held off by res (see Stall). A
// byte taken sits in the input register, is then decoded (x10 + digit,
// saturate) into the frame state, and any result it gives is registered
// in the result slot and shown on res from there.
// Stall: while res is held off, a byte that would need the busy result
// slot stays in the input register and rx.ready drops; bytes that cause
// no result keep flowing while a result waits.
// Reset: arst_n clears frame, command and decoder state and empties both
// registers; the block is ready for bytes as soon as reset is released.
// ----------------------------------------------------------------------------
module framed_ascii_command_parser_top (
	input  wire        clk,
	input  wire        arst_n,
	facp_in_if.sink    rx,
	facp_out_if.source res
);
	import facp_pkg::*;

	logic                  valid_s1;
	rx_byte_t              byte_s1;

	logic                  in_frame_q;
	cmd_kind_t             kind_q;
	logic                  appended_q;
	logic [TEXT_LEN_W-1:0] len_q;
	num_phase_t            phase_q;
	logic                  neg_q;
	logic [31:0]           mag_q;

	logic                  in_frame_d;
	cmd_kind_t             kind_d;
	logic                  appended_d;
	logic [TEXT_LEN_W-1:0] len_d;
	num_phase_t            phase_d;
	logic                  neg_d;
	logic [31:0]           mag_d;

	logic                  res_valid_q;
	command_t              command_q;
	value_t                value_q;

	cmd_kind_t             code;
	logic                  emit;
	logic                  clear;
	logic                  is_digit;
	logic                  is_space;
	logic                  is_sign;
	logic [35:0]           prod;
	logic [31:0]           cur_value;
	logic                  slot_free;
	logic                  advance;

	assign code     = letter_kind(byte_s1);
	assign is_digit = (byte_s1 >= BYTE_ZERO) && (byte_s1 <= BYTE_NINE);
	assign is_space = (byte_s1 == BYTE_SPACE) || ((byte_s1 >= BYTE_TAB) && (byte_s1 <= BYTE_CR));
	assign is_sign  = (byte_s1 == BYTE_PLUS) || (byte_s1 == BYTE_MINUS);
	assign prod     = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0}
	                + {28'd0, byte_s1 - BYTE_ZERO};
	assign cur_value = neg_q ? (32'd0 - mag_q) : ((mag_q > POS_MAX) ? POS_MAX : mag_q);

	always_comb begin
		in_frame_d = in_frame_q;
		kind_d     = kind_q;
		appended_d = appended_q;
		len_d      = len_q;
		phase_d    = phase_q;
		neg_d      = neg_q;
		mag_d      = mag_q;
		emit       = 1'b0;
		clear      = 1'b0;
		if (in_frame_q) begin
			if (code != KIND_NONE) begin
				kind_d     = code;
				appended_d = 1'b0;
			end else if (byte_s1 == BYTE_ETX) begin
				emit       = (kind_q != KIND_NONE);
				kind_d     = KIND_NONE;
				appended_d = 1'b0;
				in_frame_d = 1'b0;
				clear      = 1'b1;
			end else if (byte_s1 == BYTE_STX) begin
				if (appended_q) begin
					appended_d = 1'b0;
					kind_d     = KIND_NONE;
					clear      = 1'b1;
				end
			end else if (kind_q != KIND_NONE) begin
				appended_d = 1'b1;
				if ((byte_s1 != BYTE_NUL) && (len_q < TEXT_LEN_W'(TEXT_BYTES - 1))) begin
					len_d = len_q + 1'b1;
					if (phase_q != PH_STOP) begin
						if (is_digit) begin
							mag_d   = (prod > {4'd0, MAG_CAP}) ? MAG_CAP : prod[31:0];
							phase_d = PH_NUM;
						end else if ((phase_q == PH_SKIP) && is_space) begin
							phase_d = PH_SKIP;
						end else if ((phase_q == PH_SKIP) && is_sign) begin
							neg_d   = (byte_s1 == BYTE_MINUS);
							phase_d = PH_NUM;
						end else begin
							phase_d = PH_STOP;
						end
					end
				end
			end
		end
		if (byte_s1 == BYTE_STX) begin
			in_frame_d = 1'b1;
		end
		if (clear) begin
			len_d   = '0;
			phase_d = PH_SKIP;
			neg_d   = 1'b0;
			mag_d   = '0;
		end
	end

	assign slot_free = !res_valid_q || res.ready;
	assign advance   = valid_s1 && (slot_free || !emit);
	assign rx.ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			kind_q     <= KIND_NONE;
			appended_q <= 1'b0;
			len_q      <= '0;
			phase_q    <= PH_SKIP;
			neg_q      <= 1'b0;
			mag_q      <= '0;
		end else if (advance) begin
			in_frame_q <= in_frame_d;
			kind_q     <= kind_d;
			appended_q <= appended_d;
			len_q      <= len_d;
			phase_q    <= phase_d;
			neg_q      <= neg_d;
			mag_q      <= mag_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && emit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			command_q <= 3'(kind_q) - 3'd1;
			value_q   <= cur_value;
		end
	end

	assign res.valid   = res_valid_q;
	assign res.command = command_q;
	assign res.value   = value_q;

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the framed ASCII command parser: framed command
// text with random whitespace, signs, digit runs, junk, NUL, nested STX and
// letter changes is driven byte by byte; a scoreboard decodes the same bytes
// and checks each command beat in order, under random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
	import facp_pkg::*;

	localparam int ITEM_TARGET = 950;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		command_t command;
		value_t   value;
	} cmd_beat_t;

	class command_tracker;
		bit         in_frame;
		cmd_kind_t  kind;
		bit         appended;
		int         text_len;
		num_phase_t phase;
		bit         neg;
		logic [31:0] mag;
		cmd_beat_t  pending[$];
		int         errors;

		function new();
			in_frame = 0;
			kind = KIND_NONE;
			appended = 0;
			errors = 0;
			clear_text();
		endfunction

		function void clear_text();
			text_len = 0;
			phase = PH_SKIP;
			neg = 0;
			mag = '0;
		endfunction

		function cmd_kind_t kind_of(rx_byte_t b);
			case (b)
				LETTER_M: return KIND_M;
				LETTER_V: return KIND_V;
				LETTER_D: return KIND_D;
				LETTER_E: return KIND_E;
				LETTER_R: return KIND_R;
				default:  return KIND_NONE;
			endcase
		endfunction

		function void decode(rx_byte_t b);
			logic [63:0] m;
			bit is_space;
			bit is_digit;
			is_space = (b == BYTE_SPACE) || (b >= BYTE_TAB && b <= BYTE_CR);
			is_digit = (b >= BYTE_ZERO && b <= BYTE_NINE);
			if (phase == PH_STOP)
				return;
			if (is_digit) begin
				m = {32'd0, mag} * 64'd10 + {56'd0, b - BYTE_ZERO};
				mag = (m > {32'd0, MAG_CAP}) ? MAG_CAP : m[31:0];
				phase = PH_NUM;
			end else if (phase == PH_SKIP && is_space) begin
			end else if (phase == PH_SKIP && (b == BYTE_PLUS || b == BYTE_MINUS)) begin
				neg = (b == BYTE_MINUS);
				phase = PH_NUM;
			end else begin
				phase = PH_STOP;
			end
		endfunction

		function value_t value_now();
			if (neg)
				return value_t'(32'd0 - mag);
			return (mag > POS_MAX) ? POS_MAX : mag;
		endfunction

		function void note_byte(rx_byte_t b);
			cmd_kind_t k;
			cmd_beat_t e;
			k = kind_of(b);
			if (in_frame) begin
				if (k != KIND_NONE) begin
					kind = k;
					appended = 0;
				end else if (b == BYTE_ETX) begin
					if (kind != KIND_NONE) begin
						e.command = command_t'(kind - KIND_M);
						e.value = value_now();
						pending.push_back(e);
					end
					kind = KIND_NONE;
					appended = 0;
					in_frame = 0;
					clear_text();
				end else if (b == BYTE_STX) begin
					if (appended) begin
						appended = 0;
						kind = KIND_NONE;
						clear_text();
					end
				end else if (kind != KIND_NONE) begin
					appended = 1;
					if (b != BYTE_NUL && text_len < TEXT_BYTES - 1) begin
						text_len++;
						decode(b);
					end
				end
			end
			if (b == BYTE_STX)
				in_frame = 1;
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= 50)
				$display("mismatch: %s", msg);
		endtask

		task check_beat(command_t c, value_t v);
			cmd_beat_t e;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("unexpected beat command %0d value %0d", c, v));
				return;
			end
			e = pending.pop_front();
			if (c !== e.command)
				report_mismatch($sformatf("command %0d, want %0d", c, e.command));
			if (v !== e.value)
				report_mismatch($sformatf("value %0d, want %0d (command %0d)",
					v, e.value, e.command));
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   quiet;
	int   frame_bytes;
	int   cycles;

	facp_in_if  rx_if();
	facp_out_if res_if();

	command_tracker tracker = new;

	framed_ascii_command_parser_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.res    (res_if)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_if.ready <= quiet || ($urandom_range(99) >= 11);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			tracker.check_beat(res_if.command, res_if.value);
	end

	// entered and left at a falling edge
	task automatic send_byte(input rx_byte_t b);
		while (!quiet && $urandom_range(99) < 11) begin
			rx_if.valid <= 1'b0;
			@(negedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		@(posedge clk);
		while (!rx_if.ready)
			@(posedge clk);
		if (tracker.in_frame || b == BYTE_STX)
			frame_bytes++;
		tracker.note_byte(b);
		@(negedge clk);
	endtask

	function automatic rx_byte_t pick_letter();
		case ($urandom_range(0, 4))
			0:       return LETTER_M;
			1:       return LETTER_V;
			2:       return LETTER_D;
			3:       return LETTER_E;
			default: return LETTER_R;
		endcase
	endfunction

	function automatic rx_byte_t pick_space();
		int r;
		r = $urandom_range(0, 5);
		if (r == 0)
			return BYTE_SPACE;
		return BYTE_TAB + rx_byte_t'(r - 1);
	endfunction

	task automatic send_number_text();
		int n;
		int sel;
		string boundary;
		boundary = "214748364";
		if ($urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 3)) send_byte(pick_space());
		sel = $urandom_range(0, 3);
		if (sel == 0)
			send_byte(BYTE_MINUS);
		else if (sel == 1)
			send_byte(BYTE_PLUS);
		sel = $urandom_range(0, 99);
		if (sel < 5) begin
			foreach (boundary[i])
				send_byte(rx_byte_t'(boundary[i]));
			send_byte($urandom_range(0, 1) ? 8'h38 : 8'h37);
		end else begin
			if (sel < 20)
				n = $urandom_range(10, 12);
			else if (sel < 26)
				n = $urandom_range(15, 24);
			else
				n = $urandom_range(0, 5);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 32) == 0)
					send_byte(BYTE_NUL);
				send_byte(BYTE_ZERO + rx_byte_t'($urandom_range(0, 9)));
			end
		end
		if ($urandom_range(0, 9) < 3)
			repeat ($urandom_range(1, 2)) send_byte(rx_byte_t'($urandom_range(0, 255)));
	endtask

	task automatic send_frame();
		if ($urandom_range(0, 9) == 0)
			send_byte(rx_byte_t'($urandom_range(0, 255)));
		send_byte(BYTE_STX);
		if ($urandom_range(0, 19) != 0)
			send_byte(pick_letter());
		send_number_text();
		if ($urandom_range(0, 9) == 0) begin
			send_byte(pick_letter());
			send_number_text();
		end
		if ($urandom_range(0, 19) == 0) begin
			send_byte(BYTE_STX);
			send_byte(pick_letter());
			send_number_text();
		end
		if ($urandom_range(0, 19) != 0)
			send_byte(BYTE_ETX);
	endtask

	rx_byte_t directed [25] = '{
		8'h41, BYTE_STX, LETTER_M, BYTE_SPACE, BYTE_MINUS, 8'h37, BYTE_ETX,
		BYTE_STX, LETTER_V, BYTE_STX, BYTE_PLUS, 8'h39, BYTE_ETX,
		BYTE_STX, LETTER_D, 8'h78, BYTE_STX, LETTER_E, BYTE_ETX,
		BYTE_STX, LETTER_R, BYTE_NUL, BYTE_ETX,
		BYTE_STX, BYTE_ETX
	};

	initial begin
		arst_n = 1'b0;
		quiet = 1'b0;
		frame_bytes = 0;
		cycles = 0;
		rx_if.valid = 1'b0;
		rx_if.rx_byte = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		foreach (directed[i])
			send_byte(directed[i]);
		while (frame_bytes < ITEM_TARGET) begin
			quiet = (frame_bytes >= 350 && frame_bytes < 550);
			send_frame();
		end
		quiet = 1'b0;
		rx_if.valid <= 1'b0;
		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
